// ----- rtl/ata_request_to_taskfile_splitter_macros.svh -----
// ----------------------------------------------------------------------------
// ATA taskfile splitter assertion macros
// Shared concurrent assertion forms for the splitter checkers.
// ----------------------------------------------------------------------------
`ifndef ATA_REQUEST_TO_TASKFILE_SPLITTER_MACROS_SVH
`define ATA_REQUEST_TO_TASKFILE_SPLITTER_MACROS_SVH

// same-cycle implication
`define ATS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ats assertion failed");

// next-cycle implication
`define ATS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ats assertion failed");

`endif

// ----- rtl/ats_pkg.sv -----
// ----------------------------------------------------------------------------
// ATA taskfile splitter package
// Shared types, constants and register map for the splitter.
// ----------------------------------------------------------------------------
package ats_pkg;

	localparam int SECTOR_BYTES    = 512;
	localparam int SECTOR_SHIFT    = 9;
	localparam int DEF_CHUNK_BYTES = 65536;
	localparam int DEF_MAX_CHUNKS  = 64;

	localparam int POS_W     = 57;
	localparam int LEN_W     = 23;
	localparam int SEC_W     = 48;
	localparam int LEN_SEC_W = LEN_W - SECTOR_SHIFT;
	localparam int LBA_W     = 32;

	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 72;
	localparam int OUT_USER_W = 4;

	localparam int PADDR_W   = 5;
	localparam int PDATA_W   = 64;
	localparam int REG_IDX_W = 2;

	localparam logic [REG_IDX_W-1:0] REG_PART_START = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_PART_SIZE  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_LBA48_MODE = 2'd2;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_MISALIGNED = 3'd1,
		ST_OUTSIDE    = 3'd2,
		ST_EMPTY      = 3'd3,
		ST_OVERSIZE   = 3'd4
	} result_code_t;

	typedef struct packed {
		logic [SEC_W-1:0] part_start;
		logic [SEC_W-1:0] part_size;
		logic             lba48;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic check;
		logic setup;
		logic put_reject;
		logic put_chunk;
	} cmd_t;

	typedef struct packed {
		logic rejected;
		logic out_free;
		logic final_chunk;
	} sts_t;

endpackage

// ----- rtl/ata_request_to_taskfile_splitter.sv -----
// ----------------------------------------------------------------------------
// ATA request to taskfile splitter
// Turns a byte-addressed partition request into ATA PIO taskfile words.
// ----------------------------------------------------------------------------
// A request is accepted in S_IDLE, checked in S_CHECK and clipped and
// offset by the partition start in S_SETUP; a rejected request puts its
// one result word from S_SETUP instead. The chunk sequencer feeding the
// single output register issues one word a cycle while that register is
// free (empty or being taken). A new request is taken as soon as the last
// word of the previous one is in the output register.
module ata_request_to_taskfile_splitter #(
	parameter int CHUNK_BYTES = ats_pkg::DEF_CHUNK_BYTES,
	parameter int MAX_CHUNKS  = ats_pkg::DEF_MAX_CHUNKS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ats_pkg::PADDR_W-1:0]    paddr,
	input  logic [ats_pkg::PDATA_W-1:0]    pwdata,
	output logic [ats_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [56:0] byte_position, [79:57] byte_length
	input  logic [ats_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// [0] is_write
	input  logic                           s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [7:0] sec_cnt, [15:8] lba_low, [23:16] lba_mid, [31:24] lba_high,
	// [39:32] lba_extra, [43:40] head_nibble, [66:44] accepted_length, [71:67] 0
	output logic [ats_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// [2:0] status, [3] write_cmd
	output logic [ats_pkg::OUT_USER_W-1:0] m_axis_tuser,
	output logic                           m_axis_tlast
);

	ats_pkg::cfg_t cfg;
	ats_pkg::cmd_t cmd;
	ats_pkg::sts_t sts;

	ats_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ats_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ats_dp #(
		.CHUNK_BYTES (CHUNK_BYTES),
		.MAX_CHUNKS  (MAX_CHUNKS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

endmodule

// ----- rtl/ats_regs.sv -----
// ----------------------------------------------------------------------------
// ATA taskfile splitter registers
// APB register file for partition start, partition size and LBA layout.
// ----------------------------------------------------------------------------
module ats_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ats_pkg::PADDR_W-1:0] paddr,
	input  logic [ats_pkg::PDATA_W-1:0] pwdata,
	output logic [ats_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	output ats_pkg::cfg_t               cfg
);

	logic [ats_pkg::SEC_W-1:0]     part_start_q;
	logic [ats_pkg::SEC_W-1:0]     part_size_q;
	logic                          lba48_q;
	logic [ats_pkg::REG_IDX_W-1:0] idx;
	logic                          wr_en;

	assign idx    = paddr[ats_pkg::PADDR_W-1:ats_pkg::PADDR_W-ats_pkg::REG_IDX_W];
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_start_q <= '0;
			part_size_q  <= '0;
			lba48_q      <= 1'b0;
		end else if (wr_en) begin
			case (idx)
				ats_pkg::REG_PART_START: part_start_q <= pwdata[ats_pkg::SEC_W-1:0];
				ats_pkg::REG_PART_SIZE:  part_size_q  <= pwdata[ats_pkg::SEC_W-1:0];
				ats_pkg::REG_LBA48_MODE: lba48_q      <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			ats_pkg::REG_PART_START:
				prdata = {{(ats_pkg::PDATA_W-ats_pkg::SEC_W){1'b0}}, part_start_q};
			ats_pkg::REG_PART_SIZE:
				prdata = {{(ats_pkg::PDATA_W-ats_pkg::SEC_W){1'b0}}, part_size_q};
			ats_pkg::REG_LBA48_MODE:
				prdata = {{(ats_pkg::PDATA_W-1){1'b0}}, lba48_q};
			default:
				prdata = '0;
		endcase
	end

	assign cfg.part_start = part_start_q;
	assign cfg.part_size  = part_size_q;
	assign cfg.lba48      = lba48_q;

endmodule

// ----- rtl/ats_dp.sv -----
// ----------------------------------------------------------------------------
// ATA taskfile splitter datapath
// Request checks, partition clipping, chunk sequencing and result register.
// ----------------------------------------------------------------------------
module ats_dp #(
	parameter int CHUNK_BYTES = ats_pkg::DEF_CHUNK_BYTES,
	parameter int MAX_CHUNKS  = ats_pkg::DEF_MAX_CHUNKS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ats_pkg::cfg_t                  cfg,
	input  ats_pkg::cmd_t                  cmd,
	output ats_pkg::sts_t                  sts,
	input  logic [ats_pkg::IN_DATA_W-1:0]  in_data,
	input  logic                           in_user,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ats_pkg::OUT_DATA_W-1:0] out_data,
	output logic [ats_pkg::OUT_USER_W-1:0] out_user,
	output logic                           out_last
);

	localparam int KW = $clog2(MAX_CHUNKS + 1);
	localparam logic [31:0] MAX_LEN = 32'(MAX_CHUNKS * CHUNK_BYTES);
	localparam logic [ats_pkg::LEN_SEC_W-1:0] CHUNK_SEC =
		ats_pkg::LEN_SEC_W'(CHUNK_BYTES / ats_pkg::SECTOR_BYTES);
	localparam logic [KW-1:0] LAST_K = KW'(MAX_CHUNKS - 1);

	// request registers
	logic [ats_pkg::POS_W-1:0]     pos_q;
	logic [ats_pkg::LEN_W-1:0]     len_q;
	logic                          wr_q;
	ats_pkg::result_code_t         code_q;
	logic [ats_pkg::SEC_W-1:0]     avail_q;
	logic [ats_pkg::LEN_SEC_W-1:0] rem_q;
	logic [ats_pkg::LEN_W-1:0]     acc_q;
	logic [ats_pkg::LBA_W-1:0]     lba_q;
	logic [KW-1:0]                 k_q;

	// result register
	logic                          ovalid_q;
	ats_pkg::result_code_t         ostatus_q;
	logic                          owr_q;
	logic [7:0]                    ocount_q;
	logic [ats_pkg::LBA_W-1:0]     olba_q;
	logic                          olba48_q;
	logic [ats_pkg::LEN_W-1:0]     oacc_q;
	logic                          olast_q;

	logic [ats_pkg::SEC_W-1:0]     pos_sec;
	ats_pkg::result_code_t         code_d;
	logic [ats_pkg::LEN_SEC_W-1:0] len_sec;
	logic [ats_pkg::LEN_SEC_W-1:0] clip_sec;
	logic [ats_pkg::LEN_SEC_W-1:0] chunk;
	logic [ats_pkg::LEN_SEC_W-1:0] rem_next;
	logic                          is_final;
	logic                          out_free;

	assign pos_sec = pos_q[ats_pkg::POS_W-1:ats_pkg::SECTOR_SHIFT];
	assign len_sec = len_q[ats_pkg::LEN_W-1:ats_pkg::SECTOR_SHIFT];

	always_comb begin
		if ((|pos_q[ats_pkg::SECTOR_SHIFT-1:0]) || (|len_q[ats_pkg::SECTOR_SHIFT-1:0]))
			code_d = ats_pkg::ST_MISALIGNED;
		else if (32'(len_q) > MAX_LEN)
			code_d = ats_pkg::ST_OVERSIZE;
		else if (pos_sec >= cfg.part_size)
			code_d = ats_pkg::ST_OUTSIDE;
		else if (len_q == '0)
			code_d = ats_pkg::ST_EMPTY;
		else
			code_d = ats_pkg::ST_OK;
	end

	assign clip_sec = (ats_pkg::SEC_W'(len_sec) > avail_q) ?
		avail_q[ats_pkg::LEN_SEC_W-1:0] : len_sec;

	assign chunk    = (rem_q < CHUNK_SEC) ? rem_q : CHUNK_SEC;
	assign rem_next = rem_q - chunk;
	assign is_final = (rem_next == '0) || (k_q == LAST_K);
	assign out_free = !ovalid_q || out_ready;

	assign sts.rejected    = (code_q != ats_pkg::ST_OK);
	assign sts.out_free    = out_free;
	assign sts.final_chunk = is_final;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_q <= in_data[ats_pkg::POS_W-1:0];
			len_q <= in_data[ats_pkg::POS_W+ats_pkg::LEN_W-1:ats_pkg::POS_W];
			wr_q  <= in_user;
		end
		if (cmd.check) begin
			code_q  <= code_d;
			avail_q <= cfg.part_size - pos_sec;
		end
		if (cmd.setup) begin
			rem_q <= clip_sec;
			acc_q <= {clip_sec, {ats_pkg::SECTOR_SHIFT{1'b0}}};
			lba_q <= cfg.part_start[ats_pkg::LBA_W-1:0] +
				pos_sec[ats_pkg::LBA_W-1:0];
			k_q   <= '0;
		end else if (cmd.put_chunk) begin
			rem_q <= rem_next;
			lba_q <= lba_q + ats_pkg::LBA_W'(chunk);
			k_q   <= k_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ovalid_q <= 1'b0;
		else if (cmd.put_reject || cmd.put_chunk)
			ovalid_q <= 1'b1;
		else if (out_ready)
			ovalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.put_reject) begin
			ostatus_q <= code_q;
			owr_q     <= 1'b0;
			ocount_q  <= '0;
			olba_q    <= '0;
			olba48_q  <= 1'b0;
			oacc_q    <= '0;
			olast_q   <= 1'b1;
		end else if (cmd.put_chunk) begin
			ostatus_q <= ats_pkg::ST_OK;
			owr_q     <= wr_q;
			ocount_q  <= chunk[7:0];
			olba_q    <= lba_q;
			olba48_q  <= cfg.lba48;
			oacc_q    <= acc_q;
			olast_q   <= is_final;
		end
	end

	assign out_valid = ovalid_q;
	assign out_last  = olast_q;
	assign out_user  = {owr_q, ostatus_q};

	always_comb begin
		out_data        = '0;
		out_data[7:0]   = ocount_q;
		out_data[15:8]  = olba_q[7:0];
		out_data[23:16] = olba_q[15:8];
		out_data[31:24] = olba_q[23:16];
		out_data[39:32] = (ostatus_q == ats_pkg::ST_OK && olba48_q) ? olba_q[31:24] : 8'd0;
		out_data[43:40] = (ostatus_q == ats_pkg::ST_OK && !olba48_q) ? olba_q[27:24] : 4'd0;
		out_data[66:44] = oacc_q;
	end

endmodule

// ----- rtl/ats_ctrl.sv -----
// ----------------------------------------------------------------------------
// ATA taskfile splitter controller
// Sequences request intake, checking, setup, rejection words and per-chunk result issue.
// ----------------------------------------------------------------------------
module ats_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ats_pkg::sts_t sts,
	output ats_pkg::cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_SETUP,
		S_EMIT
	} state_t;

	state_t state_q;
	logic   ready_q;

	assign in_ready = ready_q;

	always_comb begin
		cmd            = '0;
		cmd.load       = (state_q == S_IDLE) && in_valid && ready_q;
		cmd.check      = (state_q == S_CHECK);
		cmd.setup      = (state_q == S_SETUP) && !sts.rejected;
		cmd.put_reject = (state_q == S_SETUP) && sts.rejected && sts.out_free;
		cmd.put_chunk  = (state_q == S_EMIT) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					ready_q <= !cmd.load;
					if (cmd.load)
						state_q <= S_CHECK;
				end
				S_CHECK: begin
					state_q <= S_SETUP;
				end
				S_SETUP: begin
					if (cmd.setup)
						state_q <= S_EMIT;
					else if (cmd.put_reject) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				S_EMIT: begin
					if (cmd.put_chunk && sts.final_chunk) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					ready_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

// ----- rtl/ats_checker.sv -----
// ----------------------------------------------------------------------------
// ATA taskfile splitter checker
// Port-level assertions on result words, bound to the top level.
// ----------------------------------------------------------------------------
`include "ata_request_to_taskfile_splitter_macros.svh"

module ats_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [ats_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic [ats_pkg::OUT_USER_W-1:0] m_axis_tuser,
	input logic                           m_axis_tlast
);

	logic                                                is_ok;
	logic                                                stalled;
	logic [ats_pkg::OUT_DATA_W+ats_pkg::OUT_USER_W:0]    out_bus;

	assign is_ok   = (m_axis_tuser[2:0] == ats_pkg::ST_OK);
	assign stalled = m_axis_tvalid && !m_axis_tready;
	assign out_bus = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

	// stalled word holds
	`ATS_ASSERT_NEXT(a_out_hold, clk, arst_n, stalled, m_axis_tvalid && $stable(out_bus))

	// a rejection is a single bare word
	`ATS_ASSERT_IMPLY(a_reject_bare, clk, arst_n, m_axis_tvalid && !is_ok, m_axis_tlast && m_axis_tdata == '0 && !m_axis_tuser[3])

	// only one LBA layout field is used
	`ATS_ASSERT_IMPLY(a_layout_excl, clk, arst_n, m_axis_tvalid, m_axis_tdata[39:32] == 8'd0 || m_axis_tdata[43:40] == 4'd0)

	// an issued command always carries a nonzero accepted length
	`ATS_ASSERT_IMPLY(a_issued_len, clk, arst_n, m_axis_tvalid && is_ok, m_axis_tdata[66:44] != '0)

endmodule

bind ata_request_to_taskfile_splitter ats_checker u_ats_checker (.*);
